FILE: rtl/core/wsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared codes and types for the workspace stack allocator.
// ----------------------------------------------------------------------------
package wsa_pkg;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int WORD_W   = 5;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SESSION = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_SPACE     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_MANY      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DOUBLE    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_UNALIGNED = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WS_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WS_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD     = 2'd2;

    localparam logic [WORD_W-1:0]  WORD_RESET = 5'd4;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'hF;

    // Sequencer states
    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_DIVIDE  = 10'b00_0000_0010,
        S_ROUND   = 10'b00_0000_0100,
        S_ALLOC   = 10'b00_0000_1000,
        S_SESSION = 10'b00_0001_0000,
        S_SEARCH  = 10'b00_0010_0000,
        S_MATCH   = 10'b00_0100_0000,
        S_POP     = 10'b00_1000_0000,
        S_TAIL    = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } state_t;

endpackage

FILE: rtl/core/workspace_stack_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// workspace_stack_allocator_core
// Bump-pointer workspace allocator with a stack of block end addresses.
// ----------------------------------------------------------------------------
// One word in, one word out. The block takes one request at a time and drops
// s_axis_tready while it works. Allocate and session start run a bit-serial
// remainder unit over the 32-bit operand. A zero-size allocate, a double free
// and an unused operation code answer without further work. Any other free
// searches the table from the top down (up to MAX_BLOCKS-1 entries), then pops
// cleared entries and reloads the pointer from the table. The end address
// table is a small memory with one registered read port. A finished result
// waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module workspace_stack_allocator_core #(
    parameter int MAX_BLOCKS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] request_bytes, [63:32] free_address
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] block_address, [34:32] status, rest 0
);

    localparam int TOP_W = $clog2(MAX_BLOCKS);
    localparam logic [TOP_W-1:0] TOP_LIMIT = TOP_W'(MAX_BLOCKS - 1);
    localparam logic [TOP_W-1:0] TOP_ONE   = TOP_W'(1);
    localparam int BIT_CNT_W = $clog2(wsa_pkg::ADDR_W);

    // Configuration registers
    logic [wsa_pkg::ADDR_W-1:0] ws_start_reg;
    logic [wsa_pkg::ADDR_W-1:0] ws_end_reg;
    logic [wsa_pkg::WORD_W-1:0] word_reg;

    // Allocator state
    wsa_pkg::state_t            state_reg,  state_next;
    logic [wsa_pkg::ADDR_W-1:0] next_free_reg, next_free_next;
    logic [TOP_W-1:0]           top_reg,    top_next;
    logic [wsa_pkg::COUNT_W-1:0] active_reg, active_next;
    logic [MAX_BLOCKS-1:0]      valid_reg,  valid_next;

    // Work registers
    logic [wsa_pkg::FUNC_W-1:0] func_reg,   func_next;
    logic [wsa_pkg::ADDR_W-1:0] req_reg,    req_next;
    logic [wsa_pkg::ADDR_W-1:0] ptr_reg,    ptr_next;
    logic [wsa_pkg::ADDR_W-1:0] shift_reg,  shift_next;
    logic [wsa_pkg::WORD_W-1:0] rem_reg,    rem_next;
    logic [BIT_CNT_W-1:0]       bit_reg,    bit_next;
    logic [wsa_pkg::ADDR_W:0]   bytes_reg,  bytes_next;
    logic [TOP_W-1:0]           idx_reg,    idx_next;
    logic [wsa_pkg::ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [wsa_pkg::STATUS_W-1:0] res_stat_reg, res_stat_next;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    logic [wsa_pkg::ADDR_W-1:0] out_addr_reg,  out_addr_next;
    logic [wsa_pkg::STATUS_W-1:0] out_stat_reg, out_stat_next;

    // End address memory
    logic [wsa_pkg::ADDR_W-1:0] blk_mem [MAX_BLOCKS];
    logic [wsa_pkg::ADDR_W-1:0] rd_data_reg;
    logic [TOP_W-1:0]           rd_addr;
    logic                       mem_we;

    // Shared datapath terms
    logic [wsa_pkg::WORD_W-1:0] w_eff;
    logic [wsa_pkg::WORD_W:0]   trial;
    logic [wsa_pkg::WORD_W+1:0] trial_sub;
    logic [wsa_pkg::ADDR_W+1:0] end_sum;
    logic                       in_fire;
    logic                       out_fire;

    assign w_eff    = (word_reg == '0) ? wsa_pkg::WORD_W'(1) : word_reg;
    assign trial    = {rem_reg, shift_reg[wsa_pkg::ADDR_W-1]};
    assign trial_sub = {1'b0, trial} - {2'b00, w_eff};
    assign end_sum  = {2'b00, next_free_reg} + {1'b0, bytes_reg};

    assign s_axis_tready = (state_reg == wsa_pkg::S_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = out_valid_reg && m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0_0000, out_stat_reg, out_addr_reg};

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_start_reg <= '0;
            ws_end_reg   <= '0;
            word_reg     <= wsa_pkg::WORD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wsa_pkg::CFG_WS_START: ws_start_reg <= cfg_data;
                wsa_pkg::CFG_WS_END:   ws_end_reg   <= cfg_data;
                wsa_pkg::CFG_WORD:     word_reg     <= cfg_data[wsa_pkg::WORD_W-1:0];
                default:               ;
            endcase
        end
    end

    // Pick the table read address
    always_comb
    begin
        case (state_reg)
            wsa_pkg::S_SEARCH: rd_addr = idx_reg - TOP_ONE;
            default:           rd_addr = top_reg - TOP_ONE;
        endcase
    end

    assign mem_we = (state_reg == wsa_pkg::S_ALLOC)
                 && (end_sum <= {2'b00, ws_end_reg})
                 && (top_reg < TOP_LIMIT);

    // Store block ends, read through a registered port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            blk_mem[top_reg] <= end_sum[wsa_pkg::ADDR_W-1:0];
        end
        rd_data_reg <= blk_mem[rd_addr];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        next_free_next = next_free_reg;
        top_next       = top_reg;
        active_next    = active_reg;
        valid_next     = valid_reg;
        func_next      = func_reg;
        req_next       = req_reg;
        ptr_next       = ptr_reg;
        shift_next     = shift_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        bytes_next     = bytes_reg;
        idx_next       = idx_reg;
        res_addr_next  = res_addr_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_addr_next  = out_addr_reg;
        out_stat_next  = out_stat_reg;

        case (state_reg)
            wsa_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    func_next     = s_axis_tuser;
                    req_next      = s_axis_tdata[31:0];
                    ptr_next      = s_axis_tdata[63:32];
                    rem_next      = '0;
                    bit_next      = BIT_CNT_W'(wsa_pkg::ADDR_W - 1);
                    res_addr_next = '0;
                    res_stat_next = wsa_pkg::STAT_OK;
                    state_next    = wsa_pkg::S_DONE;
                    case (s_axis_tuser)
                        wsa_pkg::FUNC_ALLOC:
                        begin
                            if (s_axis_tdata[31:0] == '0)
                            begin
                                res_stat_next = wsa_pkg::STAT_ZERO;
                            end
                            else
                            begin
                                shift_next = s_axis_tdata[31:0];
                                state_next = wsa_pkg::S_DIVIDE;
                            end
                        end
                        wsa_pkg::FUNC_FREE:
                        begin
                            if (active_reg == '0)
                            begin
                                next_free_next = ws_start_reg;
                                res_stat_next  = wsa_pkg::STAT_DOUBLE;
                            end
                            else
                            begin
                                active_next = active_reg - wsa_pkg::COUNT_W'(1);
                                if (s_axis_tdata[63:32] == ws_start_reg)
                                begin
                                    valid_next[0] = 1'b0;
                                    state_next    = wsa_pkg::S_POP;
                                end
                                else
                                begin
                                    idx_next   = top_reg;
                                    state_next = wsa_pkg::S_SEARCH;
                                end
                            end
                        end
                        wsa_pkg::FUNC_SESSION:
                        begin
                            shift_next = ws_start_reg;
                            state_next = wsa_pkg::S_DIVIDE;
                        end
                        default: ;
                    endcase
                end
            end

            // One remainder bit per cycle
            wsa_pkg::S_DIVIDE:
            begin
                rem_next   = trial_sub[wsa_pkg::WORD_W+1]
                           ? trial[wsa_pkg::WORD_W-1:0]
                           : trial_sub[wsa_pkg::WORD_W-1:0];
                shift_next = {shift_reg[wsa_pkg::ADDR_W-2:0], 1'b0};
                bit_next   = bit_reg - BIT_CNT_W'(1);
                if (bit_reg == '0)
                begin
                    state_next = (func_reg == wsa_pkg::FUNC_ALLOC)
                               ? wsa_pkg::S_ROUND : wsa_pkg::S_SESSION;
                end
            end

            // Round the request up to whole words
            wsa_pkg::S_ROUND:
            begin
                bytes_next = {1'b0, req_reg}
                           + ((rem_reg == '0) ? '0
                              : (wsa_pkg::ADDR_W + 1)'(w_eff - rem_reg));
                state_next = wsa_pkg::S_ALLOC;
            end

            wsa_pkg::S_ALLOC:
            begin
                state_next = wsa_pkg::S_DONE;
                if (end_sum > {2'b00, ws_end_reg})
                begin
                    res_stat_next = wsa_pkg::STAT_SPACE;
                end
                else if (top_reg >= TOP_LIMIT)
                begin
                    res_stat_next = wsa_pkg::STAT_MANY;
                end
                else
                begin
                    res_addr_next       = next_free_reg;
                    next_free_next      = end_sum[wsa_pkg::ADDR_W-1:0];
                    valid_next[top_reg] = 1'b1;
                    top_next            = top_reg + TOP_ONE;
                    if (active_reg != wsa_pkg::COUNT_MAX)
                    begin
                        active_next = active_reg + wsa_pkg::COUNT_W'(1);
                    end
                end
            end

            wsa_pkg::S_SESSION:
            begin
                state_next = wsa_pkg::S_DONE;
                if (rem_reg != '0)
                begin
                    res_stat_next = wsa_pkg::STAT_UNALIGNED;
                end
                else
                begin
                    next_free_next = ws_start_reg;
                    active_next    = '0;
                    top_next       = '0;
                    valid_next     = '0;
                end
            end

            // Walk the table from the top, one entry read per visit
            wsa_pkg::S_SEARCH:
            begin
                state_next = (idx_reg == '0) ? wsa_pkg::S_POP : wsa_pkg::S_MATCH;
            end

            wsa_pkg::S_MATCH:
            begin
                if (valid_reg[idx_reg - TOP_ONE] && (rd_data_reg == ptr_reg))
                begin
                    valid_next[idx_reg] = 1'b0;
                    state_next          = wsa_pkg::S_POP;
                end
                else
                begin
                    idx_next   = idx_reg - TOP_ONE;
                    state_next = wsa_pkg::S_SEARCH;
                end
            end

            // Drop cleared entries off the top
            wsa_pkg::S_POP:
            begin
                if (top_reg == '0)
                begin
                    next_free_next = ws_start_reg;
                    state_next     = wsa_pkg::S_DONE;
                end
                else if (!valid_reg[top_reg - TOP_ONE])
                begin
                    top_next = top_reg - TOP_ONE;
                end
                else
                begin
                    state_next = wsa_pkg::S_TAIL;
                end
            end

            wsa_pkg::S_TAIL:
            begin
                next_free_next = rd_data_reg;
                state_next     = wsa_pkg::S_DONE;
            end

            // Hand the result to the output register once it is free
            wsa_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_stat_next  = res_stat_reg;
                    state_next     = wsa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = wsa_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wsa_pkg::S_IDLE;
            next_free_reg <= '0;
            top_reg       <= '0;
            active_reg    <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            top_reg       <= top_next;
            active_reg    <= active_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        req_reg      <= req_next;
        ptr_reg      <= ptr_next;
        shift_reg    <= shift_next;
        rem_reg      <= rem_next;
        bit_reg      <= bit_next;
        bytes_reg    <= bytes_next;
        idx_reg      <= idx_next;
        res_addr_reg <= res_addr_next;
        res_stat_reg <= res_stat_next;
        out_addr_reg <= out_addr_next;
        out_stat_reg <= out_stat_next;
    end

    // Checks
    top_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TOP_LIMIT)
        else $error("table top beyond last usable entry");

    valid_above_top_a: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg >> top_reg) == '0)
        else $error("live entry above table top");

    busy_after_accept_a: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("request accepted while previous one in flight");

    result_from_done_a: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == wsa_pkg::S_DONE))
        else $error("result raised outside done state");

    out_fire_clears_a: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && state_reg != wsa_pkg::S_DONE) |=> !out_valid_reg)
        else $error("result word repeated");

endmodule
